/* design/dfc_pkg.sv */
`timescale 1ns / 1ps
// dfc_pkg: shared types and constants of the detector frame correction block
// no dependencies

package dfc_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam logic [15:0] PEDESTAL = 16'd100;
    localparam int GAIN_SHIFT = 10;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_DEFECT = 2'd1,
        MODE_READ   = 2'd2,
        MODE_READ3  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OUTSIDE  = 2'd1,
        ST_NO_NEIGH = 2'd2,
        ST_UNUSED   = 2'd3
    } status_t;

    localparam logic [2:0] REG_OFFSET_EN = 3'd0;
    localparam logic [2:0] REG_GAIN_EN   = 3'd1;
    localparam logic [2:0] REG_SAT       = 3'd2;
    localparam logic [2:0] REG_ROWS      = 3'd3;
    localparam logic [2:0] REG_COLS      = 3'd4;

    typedef struct packed {
        logic        offset_en;
        logic        gain_en;
        logic [15:0] sat;
        logic [12:0] rows;
        logic [12:0] cols;
    } cfg_t;

    // neighbour offsets, index k of the mask
    function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
        logic signed [1:0] r;
        begin
            unique case (k)
                3'd0, 3'd3, 3'd5: r = -2'sd1;
                3'd1, 3'd6:       r = 2'sd0;
                default:          r = 2'sd1;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
        logic signed [1:0] r;
        begin
            unique case (k)
                3'd0, 3'd1, 3'd2: r = -2'sd1;
                3'd3, 3'd4:       r = 2'sd0;
                default:          r = 2'sd1;
            endcase
            return r;
        end
    endfunction

endpackage

/* design/dfc_regs.sv */
`timescale 1ns / 1ps
// dfc_regs: apb register file for the frame correction settings
// depends on dfc_pkg

module dfc_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output dfc_pkg::cfg_t      cfg
);

    dfc_pkg::cfg_t cfg_reg;
    logic [2:0] idx;

    assign idx = paddr[4:2];
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_en <= 1'b0;
            cfg_reg.gain_en   <= 1'b0;
            cfg_reg.sat       <= 16'd100;
            cfg_reg.rows      <= 13'd1024;
            cfg_reg.cols      <= 13'd1024;
        end
        else if (psel && penable && pwrite)
        begin
            if (idx == dfc_pkg::REG_OFFSET_EN) cfg_reg.offset_en <= pwdata[0];
            if (idx == dfc_pkg::REG_GAIN_EN)   cfg_reg.gain_en   <= pwdata[0];
            if (idx == dfc_pkg::REG_SAT)       cfg_reg.sat       <= pwdata[15:0];
            if (idx == dfc_pkg::REG_ROWS)      cfg_reg.rows      <= pwdata[12:0];
            if (idx == dfc_pkg::REG_COLS)      cfg_reg.cols      <= pwdata[12:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (idx == dfc_pkg::REG_OFFSET_EN) prdata = {31'd0, cfg_reg.offset_en};
        if (idx == dfc_pkg::REG_GAIN_EN)   prdata = {31'd0, cfg_reg.gain_en};
        if (idx == dfc_pkg::REG_SAT)       prdata = {16'd0, cfg_reg.sat};
        if (idx == dfc_pkg::REG_ROWS)      prdata = {19'd0, cfg_reg.rows};
        if (idx == dfc_pkg::REG_COLS)      prdata = {19'd0, cfg_reg.cols};
    end

endmodule

/* design/dfc_divider.sv */
`timescale 1ns / 1ps
// dfc_divider: restoring divider, one quotient bit per cycle
// no package dependencies

module dfc_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [25:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [25:0] quotient
);

    logic [25:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic [17:0] diff;

    assign trial = {rem_reg[15:0], quo_reg[25]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};

    always_comb
    begin
        if (!diff[17])
        begin
            rem_next = diff[16:0];
            quo_next = {quo_reg[24:0], 1'b1};
        end
        else
        begin
            rem_next = trial;
            quo_next = {quo_reg[24:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd25)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 17'd0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/dfc_store.sv */
`timescale 1ns / 1ps
// dfc_store: single-port pixel memory, registered read
// depends on dfc_pkg

module dfc_store (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       we,
    input  logic [dfc_pkg::ADDR_W-1:0] addr,
    input  logic [15:0]                wdata,
    output logic [15:0]                rdata
);

    logic [15:0] mem [0:(1 << dfc_pkg::ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

/* design/detector_frame_correction_top.sv */
`timescale 1ns / 1ps
// detector frame correction: load, defect repair and read over a single-port pixel store
// in_stall drops in the same cycle that out_valid rises, so a new transfer can be taken
// while the result is presented; gain and averages share one bit-serial divider;
// a result held by out_stall only delays the next result; reset: rst_n asynchronous
// resets control and the configuration registers to their defaults, the datapath registers
// and the pixel store are not cleared; depends on dfc_pkg, dfc_regs, dfc_divider, dfc_store

module detector_frame_correction_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [11:0] row,
    input  logic [11:0] col,
    input  logic [15:0] sample_a,
    input  logic [15:0] sample_b,
    input  logic [15:0] gain_coef,
    input  logic [7:0]  neighbor_mask,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pixel_value,
    output logic [1:0]  status
);

    localparam int AW = dfc_pkg::ADDR_W;
    localparam int RW = dfc_pkg::ROW_W;
    localparam int CW = dfc_pkg::COL_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_NB, S_NB_LAST, S_SELF, S_SELF_WAIT, S_DIV, S_DIV_WAIT,
        S_WRITE, S_OUT
    } state_t;

    dfc_pkg::cfg_t cfg;
    state_t state_reg;

    logic [1:0]  mode_reg;
    logic [11:0] row_reg, col_reg;
    logic [15:0] a_reg, b_reg, g_reg;
    logic [7:0]  mask_reg;
    logic [2:0]  k_reg;
    logic        rd_pend_reg;
    logic [18:0] sum_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] val_reg;
    logic [1:0]  stat_reg;
    logic        out_valid_reg;
    logic [15:0] out_val_reg;
    logic [1:0]  out_stat_reg;
    logic        out_load;

    logic        mem_en, mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0] mem_wdata, mem_rdata;

    logic        div_start, div_done;
    logic [25:0] div_dividend, div_q;
    logic [15:0] div_divisor;

    logic [12:0] eff_rows, eff_cols;
    logic        in_frame;
    logic signed [1:0] dr_k, dc_k;
    logic [12:0] nr, nc;
    logic        nb_ok;
    logic [15:0] off_val;
    logic [16:0] a_minus_b, b_minus_a;

    dfc_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    dfc_store u_store (
        .clk(clk), .en(mem_en), .we(mem_we), .addr(mem_addr),
        .wdata(mem_wdata), .rdata(mem_rdata)
    );

    dfc_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .done(div_done), .quotient(div_q)
    );

    assign eff_rows = (cfg.rows < 13'(dfc_pkg::MAX_ROWS)) ? cfg.rows : 13'(dfc_pkg::MAX_ROWS);
    assign eff_cols = (cfg.cols < 13'(dfc_pkg::MAX_COLS)) ? cfg.cols : 13'(dfc_pkg::MAX_COLS);
    assign in_frame = ({1'b0, row_reg} < eff_rows) && ({1'b0, col_reg} < eff_cols);

    assign dr_k = dfc_pkg::nb_dr(k_reg);
    assign dc_k = dfc_pkg::nb_dc(k_reg);

    // neighbour coordinate, wraps to all ones when stepping below zero
    assign nr = {1'b0, row_reg} + {{11{dr_k[1]}}, dr_k};
    assign nc = {1'b0, col_reg} + {{11{dc_k[1]}}, dc_k};
    assign nb_ok = mask_reg[k_reg] && (nr < eff_rows) && (nc < eff_cols);

    assign a_minus_b = {1'b0, a_reg} - {1'b0, b_reg};
    assign b_minus_a = {1'b0, b_reg} - {1'b0, a_reg};

    always_comb
    begin
        if (a_reg >= cfg.sat)
            off_val = cfg.sat;
        else if (a_reg >= b_reg)
            off_val = ({1'b0, a_minus_b[15:0]} + {1'b0, dfc_pkg::PEDESTAL} > 17'hFFFF)
                ? 16'hFFFF : a_minus_b[15:0] + dfc_pkg::PEDESTAL;
        else if (b_minus_a[15:0] <= dfc_pkg::PEDESTAL)
            off_val = dfc_pkg::PEDESTAL - b_minus_a[15:0];
        else
            off_val = dfc_pkg::PEDESTAL;
    end

    // the output register frees the working registers while a result waits
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign pixel_value = out_val_reg;
    assign status = out_stat_reg;

    always_comb
    begin
        mem_en = 1'b0;
        mem_we = 1'b0;
        mem_addr = {row_reg[RW-1:0], col_reg[CW-1:0]};
        mem_wdata = val_reg;
        div_start = 1'b0;
        div_dividend = {10'd0, off_val} << dfc_pkg::GAIN_SHIFT;
        div_divisor = g_reg;
        unique case (state_reg)
            S_NB:
            begin
                mem_en = nb_ok;
                mem_addr = {nr[RW-1:0], nc[CW-1:0]};
            end
            S_SELF: mem_en = 1'b1;
            S_DECIDE:
            begin
                div_start = in_frame && mode_reg == dfc_pkg::MODE_LOAD && cfg.offset_en
                    && cfg.gain_en && g_reg != 16'd0;
            end
            S_DIV:
            begin
                div_start = 1'b1;
                div_dividend = {7'd0, sum_reg};
                div_divisor = {12'd0, cnt_reg};
            end
            S_WRITE:
            begin
                mem_en = 1'b1;
                mem_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && !in_stall)
                        state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    rd_pend_reg <= 1'b0;
                    if (!in_frame)
                        state_reg <= S_OUT;
                    else
                    begin
                        unique case (mode_reg)
                            dfc_pkg::MODE_LOAD:
                                state_reg <= (cfg.offset_en && cfg.gain_en && g_reg != 16'd0)
                                    ? S_DIV_WAIT : S_WRITE;
                            dfc_pkg::MODE_DEFECT: state_reg <= S_NB;
                            default: state_reg <= S_SELF;
                        endcase
                    end
                end
                S_NB:
                begin
                    rd_pend_reg <= nb_ok;
                    if (k_reg == 3'd7)
                        state_reg <= S_NB_LAST;
                end
                S_NB_LAST:
                begin
                    rd_pend_reg <= 1'b0;
                    state_reg <= (cnt_reg == 4'd0) ? S_SELF : S_DIV;
                end
                S_SELF: state_reg <= S_SELF_WAIT;
                S_SELF_WAIT: state_reg <= S_OUT;
                S_DIV: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                    if (div_done)
                        state_reg <= S_WRITE;
                S_WRITE: state_reg <= S_OUT;
                S_OUT:
                    if (out_load)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                mode_reg <= mode;
                row_reg <= row;
                col_reg <= col;
                a_reg <= sample_a;
                b_reg <= sample_b;
                g_reg <= gain_coef;
                mask_reg <= neighbor_mask;
                k_reg <= 3'd0;
                sum_reg <= 19'd0;
                cnt_reg <= 4'd0;
            end
            S_DECIDE:
            begin
                stat_reg <= in_frame ? dfc_pkg::ST_OK : dfc_pkg::ST_OUTSIDE;
                if (!in_frame)
                    val_reg <= 16'd0;
                else if (!cfg.offset_en)
                    val_reg <= a_reg;
                else if (!cfg.gain_en)
                    val_reg <= off_val;
                else
                    val_reg <= cfg.sat;
            end
            S_NB:
            begin
                k_reg <= k_reg + 3'd1;
                if (nb_ok)
                    cnt_reg <= cnt_reg + 4'd1;
                if (rd_pend_reg)
                    sum_reg <= sum_reg + {3'd0, mem_rdata};
            end
            S_NB_LAST:
                if (rd_pend_reg)
                    sum_reg <= sum_reg + {3'd0, mem_rdata};
            S_SELF_WAIT:
            begin
                val_reg <= mem_rdata;
                if (mode_reg == dfc_pkg::MODE_DEFECT)
                    stat_reg <= dfc_pkg::ST_NO_NEIGH;
            end
            S_DIV_WAIT:
                if (div_done)
                begin
                    if (mode_reg == dfc_pkg::MODE_DEFECT)
                        val_reg <= div_q[15:0];
                    else if (div_q >= {10'd0, cfg.sat})
                        val_reg <= cfg.sat;
                    else
                        val_reg <= div_q[15:0];
                end
            S_OUT:
                if (out_load)
                begin
                    out_val_reg <= val_reg;
                    out_stat_reg <= stat_reg;
                end
            default: ;
        endcase
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output step");
    a_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> in_frame && stat_reg == dfc_pkg::ST_OK)
        else $error("write to a pixel outside frame");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'd8)
        else $error("neighbour count overflow");

endmodule
